// ===== src/gbcf_pkg.sv =====
// Shared types, constants and codes for the gyro bias calibration filter.
// Used by every module of the block; depends on nothing else.
package gbcf_pkg;

    // Calibration sample count limits.
    localparam int MAX_CAL_SAMPLES = 4000;
    localparam int CAL_DEFAULT     = 512;

    // Field and datapath widths.
    localparam int AXIS_W    = 16;
    localparam int RAW_CNT_W = 16;
    localparam int COUNT_W   = 12;
    localparam int SCALE_W   = 10;
    localparam int DBAND_W   = 15;
    localparam int ACC_W     = 28;
    localparam int COND_W    = 17;
    localparam int STEP_W    = 17;
    localparam int SMOOTH_W  = 18;
    localparam int DIFF_W    = 19;
    localparam int FILT_SHIFT = 2;

    // Shared divider sizing and step counts.
    localparam int DIV_W          = 28;
    localparam int DIVISOR_W      = 12;
    localparam int DIV_CNT_W      = 5;
    localparam int CAL_DIV_STEPS  = 28;
    localparam int COND_DIV_STEPS = 17;

    // Command queue depth, pointer width and fill count width.
    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = 1;
    localparam int CMD_CNT_W = 2;

    // Saturation bounds of the filtered rate.
    localparam logic signed [SMOOTH_W-1:0] SAT_HI = 18'sd32767;
    localparam logic signed [SMOOTH_W-1:0] SAT_LO = -18'sd32768;

    // Configuration register indexes.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 15;
    localparam logic [CFG_AW-1:0] CFG_GYRO_SCALE    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_GYRO_DEADBAND = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SWAP_HALVES   = 2'd2;

    // Input opcodes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef logic signed [AXIS_W-1:0] t_s16;
    typedef t_s16 [2:0] t_triple;

    typedef enum logic {
        K_SAMPLE = 1'b0,
        K_START  = 1'b1
    } t_kind;

    // One classified command between the front and the back.
    typedef struct packed {
        t_kind               kind;
        logic [COUNT_W-1:0]  count;
        t_triple             first;
        t_triple             second;
    } t_cmd;

    // One finished result.
    typedef struct packed {
        t_triple             first;
        t_triple             rate;
        logic [COUNT_W-1:0]  samples_left;
        logic                offset_known;
    } t_result;

    // Conditioning settings seen by the back.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [DBAND_W-1:0] deadband;
    } t_cfg;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [DIV_CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/gbcf_front.sv =====
// Front end: accepts input beats, zeroes invalid triples, applies the swap
// and queues starts and samples with a valid triple. Depends on gbcf_pkg.
module gbcf_front
    import gbcf_pkg::*;
(
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic                 i_opcode,
    input  t_s16                 i_accel_x,
    input  t_s16                 i_accel_y,
    input  t_s16                 i_accel_z,
    input  t_s16                 i_gyro_x,
    input  t_s16                 i_gyro_y,
    input  t_s16                 i_gyro_z,
    input  logic                 i_accel_valid,
    input  logic                 i_gyro_valid,
    input  logic [RAW_CNT_W-1:0] i_calibration_count,
    input  logic                 i_swap,
    output logic                 o_cmd_push,
    output t_cmd                 o_cmd
);

    t_triple            acc;
    t_triple            gyr;
    logic [COUNT_W-1:0] count;
    logic               is_start;

    // Invalid triples read as zeros.
    assign acc = i_accel_valid ? {i_accel_z, i_accel_y, i_accel_x} : '0;
    assign gyr = i_gyro_valid ? {i_gyro_z, i_gyro_y, i_gyro_x} : '0;

    // A zero count means the default, and large counts are clamped.
    always_comb begin
        priority if (i_calibration_count == '0) begin
            count = COUNT_W'(CAL_DEFAULT);
        end else if (i_calibration_count > RAW_CNT_W'(MAX_CAL_SAMPLES)) begin
            count = COUNT_W'(MAX_CAL_SAMPLES);
        end else begin
            count = i_calibration_count[COUNT_W-1:0];
        end
    end

    assign is_start = (i_opcode == OP_START);

    // Samples with neither triple present are taken and dropped.
    assign o_cmd_push = i_push && !i_full && (is_start || i_accel_valid || i_gyro_valid);

    assign o_cmd.kind   = is_start ? K_START : K_SAMPLE;
    assign o_cmd.count  = count;
    assign o_cmd.first  = i_swap ? gyr : acc;
    assign o_cmd.second = i_swap ? acc : gyr;

endmodule

// ===== src/gbcf_fifo.sv =====
// Short command queue between the front and the back end.
// Depends on gbcf_pkg for the command type and depth.
module gbcf_fifo
    import gbcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0]    r_wp, n_wp;
    logic [CMD_AW-1:0]    r_rp, n_rp;
    logic [CMD_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== src/gbcf_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on gbcf_pkg for the request and response types.
module gbcf_div
    import gbcf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_num, n_num;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIVISOR_W-1:0] r_den, n_den;
    logic [DIVISOR_W:0]   trial;

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // One trial subtraction per cycle, dividend bits taken from the top.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_num[DIV_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_num  = i_req.dividend;
            n_quo  = '0;
            n_rem  = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIVISOR_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVISOR_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_num = {r_num[DIV_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

endmodule

// ===== src/gbcf_back.sv =====
// Back end: sequencer that runs calibration, bias removal, deadband,
// scaling and the IIR filter one axis at a time. Depends on gbcf_pkg.
module gbcf_back
    import gbcf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_cmd     i_cmd,
    input  logic     i_cmd_empty,
    output logic     o_cmd_pop,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_CAL_ISSUE  = 9'b000000010,
        S_CAL_WAIT   = 9'b000000100,
        S_COND_SUB   = 9'b000001000,
        S_COND_ISSUE = 9'b000010000,
        S_COND_WAIT  = 9'b000100000,
        S_FILT_A     = 9'b001000000,
        S_FILT_B     = 9'b010000000,
        S_EMIT       = 9'b100000000
    } t_back_state;

    t_back_state               r_state, n_state;
    logic [1:0]                r_axis, n_axis;
    t_triple                   r_first, n_first;
    t_triple                   r_second, n_second;
    t_triple                   r_rate, n_rate;
    logic [COUNT_W-1:0]        r_goal, n_goal;
    logic [COUNT_W-1:0]        r_left, n_left;
    logic signed [ACC_W-1:0]   r_accum [3];
    logic signed [ACC_W-1:0]   n_accum [3];
    logic signed [AXIS_W-1:0]  r_offset [3];
    logic signed [AXIS_W-1:0]  n_offset [3];
    logic                      r_ok, n_ok;
    logic signed [SMOOTH_W-1:0] r_smooth [3];
    logic signed [SMOOTH_W-1:0] n_smooth [3];
    logic signed [COND_W-1:0]  r_v, n_v;
    logic                      r_neg, n_neg;
    logic signed [SMOOTH_W-1:0] r_shaped, n_shaped;
    logic signed [STEP_W-1:0]  r_step, n_step;

    logic signed [ACC_W-1:0]    cal_acc;
    logic [DIV_W-1:0]           cal_mag;
    logic [DIVISOR_W-1:0]       goal_eff;
    logic signed [COND_W-1:0]   cond_off;
    logic [COND_W-1:0]          cond_mag;
    logic [COND_W-1:0]          cond_num;
    logic [SCALE_W-1:0]         scale_eff;
    logic [SMOOTH_W-1:0]        shaped_mag;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   biased;
    logic signed [SMOOTH_W-1:0] fsum;
    logic                       cond_active;

    assign o_res_valid       = (r_state == S_EMIT);
    assign o_res.first        = r_first;
    assign o_res.rate         = r_rate;
    assign o_res.samples_left = r_left;
    assign o_res.offset_known = r_ok;

    // Conditioning runs once a bias is known or when shaping is not identity.
    assign cond_active = r_ok || (i_cfg.deadband != '0) || (i_cfg.scale != SCALE_W'(1));
    assign scale_eff   = (i_cfg.scale == '0) ? SCALE_W'(1) : i_cfg.scale;
    assign goal_eff    = (r_goal == '0) ? DIVISOR_W'(1) : r_goal;

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_first  = r_first;
        n_second = r_second;
        n_rate   = r_rate;
        n_goal   = r_goal;
        n_left   = r_left;
        n_accum  = r_accum;
        n_offset = r_offset;
        n_ok     = r_ok;
        n_smooth = r_smooth;
        n_v      = r_v;
        n_neg    = r_neg;
        n_shaped = r_shaped;
        n_step   = r_step;
        o_cmd_pop = 1'b0;
        o_div_req = '0;

        cal_acc    = r_accum[r_axis];
        cal_mag    = cal_acc[ACC_W-1] ? $unsigned(-cal_acc) : $unsigned(cal_acc);
        cond_off   = r_ok ? COND_W'(r_offset[r_axis]) : '0;
        cond_mag   = r_v[COND_W-1] ? $unsigned(-r_v) : $unsigned(r_v);
        cond_num   = cond_mag + COND_W'(scale_eff >> 1);
        shaped_mag = {1'b0, i_div_rsp.quotient[COND_W-1:0]};
        diff       = DIFF_W'(r_shaped) - DIFF_W'(r_smooth[r_axis]);
        biased     = diff + (diff[DIFF_W-1] ? DIFF_W'((1 << FILT_SHIFT) - 1) : '0);
        fsum       = r_smooth[r_axis] + SMOOTH_W'(r_step);

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == K_START) begin
                        // Restart calibration from a clean slate.
                        n_goal = i_cmd.count;
                        n_left = i_cmd.count;
                        n_ok   = 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            n_accum[i]  = '0;
                            n_smooth[i] = '0;
                        end
                    end else begin
                        n_first  = i_cmd.first;
                        n_second = i_cmd.second;
                        n_axis   = '0;
                        if (r_left != '0) begin
                            // Collect one calibration sample; rates read zero.
                            for (int i = 0; i < 3; i++) begin
                                n_accum[i] = r_accum[i] + ACC_W'($signed(i_cmd.second[i]));
                            end
                            n_rate  = '0;
                            n_left  = r_left - 1'b1;
                            n_state = (r_left == COUNT_W'(1)) ? S_CAL_ISSUE : S_EMIT;
                        end else if (cond_active) begin
                            n_state = S_COND_SUB;
                        end else begin
                            n_rate  = i_cmd.second;
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_CAL_ISSUE: begin
                // Bias is the sum over the goal, truncated toward zero.
                o_div_req.start    = 1'b1;
                o_div_req.dividend = cal_mag;
                o_div_req.divisor  = goal_eff;
                o_div_req.steps    = DIV_CNT_W'(CAL_DIV_STEPS);
                n_neg   = cal_acc[ACC_W-1];
                n_state = S_CAL_WAIT;
            end
            S_CAL_WAIT: begin
                if (i_div_rsp.done) begin
                    n_offset[r_axis] = r_neg ? -$signed(i_div_rsp.quotient[AXIS_W-1:0])
                                             : $signed(i_div_rsp.quotient[AXIS_W-1:0]);
                    if (r_axis == 2'd2) begin
                        n_ok = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            n_smooth[i] = '0;
                        end
                        n_state = S_EMIT;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_CAL_ISSUE;
                    end
                end
            end
            S_COND_SUB: begin
                // Remove the bias once one is known.
                n_v     = COND_W'($signed(r_second[r_axis])) - cond_off;
                n_state = S_COND_ISSUE;
            end
            S_COND_ISSUE: begin
                if ((i_cfg.deadband != '0) && (cond_mag < COND_W'(i_cfg.deadband))) begin
                    n_shaped = '0;
                    n_state  = S_FILT_A;
                end else begin
                    // Round half away from zero by dividing the biased magnitude.
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {cond_num, {(DIV_W - COND_W){1'b0}}};
                    o_div_req.divisor  = DIVISOR_W'(scale_eff);
                    o_div_req.steps    = DIV_CNT_W'(COND_DIV_STEPS);
                    n_neg   = r_v[COND_W-1];
                    n_state = S_COND_WAIT;
                end
            end
            S_COND_WAIT: begin
                if (i_div_rsp.done) begin
                    n_shaped = r_neg ? -$signed(shaped_mag) : $signed(shaped_mag);
                    n_state  = S_FILT_A;
                end
            end
            S_FILT_A: begin
                // Quarter of the difference, truncated toward zero.
                n_step  = biased[DIFF_W-1:FILT_SHIFT];
                n_state = S_FILT_B;
            end
            S_FILT_B: begin
                n_smooth[r_axis] = fsum;
                priority if (fsum > SAT_HI) begin
                    n_rate[r_axis] = SAT_HI[AXIS_W-1:0];
                end else if (fsum < SAT_LO) begin
                    n_rate[r_axis] = SAT_LO[AXIS_W-1:0];
                end else begin
                    n_rate[r_axis] = fsum[AXIS_W-1:0];
                end
                if (r_axis == 2'd2) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_COND_SUB;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer and calibration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_goal  <= '0;
            r_left  <= '0;
            r_ok    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_accum[i]  <= '0;
                r_offset[i] <= '0;
                r_smooth[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_goal   <= n_goal;
            r_left   <= n_left;
            r_ok     <= n_ok;
            r_accum  <= n_accum;
            r_offset <= n_offset;
            r_smooth <= n_smooth;
        end
    end

    // Working payload of the current item.
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
        r_rate   <= n_rate;
        r_v      <= n_v;
        r_neg    <= n_neg;
        r_shaped <= n_shaped;
        r_step   <= n_step;
    end

endmodule

// ===== src/gyro_bias_calibrate_filter.sv =====
// Top level of the gyro bias calibration filter: configuration registers,
// front end, command queue, back end, shared divider and result register.
// Depends on gbcf_pkg, gbcf_front, gbcf_fifo, gbcf_div and gbcf_back.
//
// Usage. Input beats are pushed with push while full is low: a motion
// sample or a start-calibration command. Commands and samples with no valid
// triple give no result. Results come out through a one-entry register:
// while empty is low the oldest result is on the o_ ports and pop takes it.
// Configuration is written through i_cfg_we, i_cfg_addr and i_cfg_wdata
// while the block is idle (0 gyro scale, 1 gyro deadband, 2 swap halves).
// A pass-through or calibration sample passes from the queue straight to the
// result register; a conditioned sample takes three 17-step passes of the
// shared serial divider plus subtract, issue, hand-off and filter work per
// axis (an axis that the deadband zeroes needs no division). The sample that
// completes calibration runs three 28-step divisions. The back end works on
// one item at a time; a two-entry queue lets the front take beats meanwhile.
// When pop is held low the result waits and the back end stalls with it,
// then the queue fills and full rises.
// Reset is synchronous, active low, and clears control, calibration and config.
module gyro_bias_calibrate_filter
    import gbcf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_opcode,
    input  t_s16                 i_accel_x,
    input  t_s16                 i_accel_y,
    input  t_s16                 i_accel_z,
    input  t_s16                 i_gyro_x,
    input  t_s16                 i_gyro_y,
    input  t_s16                 i_gyro_z,
    input  logic                 i_accel_valid,
    input  logic                 i_gyro_valid,
    input  logic [RAW_CNT_W-1:0] i_calibration_count,
    output logic                 empty,
    input  logic                 pop,
    output t_s16                 o_first_x,
    output t_s16                 o_first_y,
    output t_s16                 o_first_z,
    output t_s16                 o_rate_x_out,
    output t_s16                 o_rate_y_out,
    output t_s16                 o_rate_z_out,
    output logic [COUNT_W-1:0]   o_samples_left,
    output logic                 o_offset_known,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wdata
);

    logic [SCALE_W-1:0] r_scale;
    logic [DBAND_W-1:0] r_deadband;
    logic               r_swap;
    logic               r_out_valid;
    t_result            r_out;

    t_cfg     cfg;
    t_cmd     cmd_in;
    t_cmd     cmd_head;
    logic     cmd_push;
    logic     cmd_pop;
    logic     cmd_full;
    logic     cmd_empty;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_W'(1);
            r_deadband <= '0;
            r_swap     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GYRO_SCALE:    r_scale    <= i_cfg_wdata[SCALE_W-1:0];
                CFG_GYRO_DEADBAND: r_deadband <= i_cfg_wdata[DBAND_W-1:0];
                CFG_SWAP_HALVES:   r_swap     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.scale    = r_scale;
    assign cfg.deadband = r_deadband;
    assign full         = cmd_full;

    gbcf_front u_front (
        .i_push              (push),
        .i_full              (cmd_full),
        .i_opcode            (i_opcode),
        .i_accel_x           (i_accel_x),
        .i_accel_y           (i_accel_y),
        .i_accel_z           (i_accel_z),
        .i_gyro_x            (i_gyro_x),
        .i_gyro_y            (i_gyro_y),
        .i_gyro_z            (i_gyro_z),
        .i_accel_valid       (i_accel_valid),
        .i_gyro_valid        (i_gyro_valid),
        .i_calibration_count (i_calibration_count),
        .i_swap              (r_swap),
        .o_cmd_push          (cmd_push),
        .o_cmd               (cmd_in)
    );

    gbcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    gbcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    gbcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // Result register: refilled in the same cycle as it is popped.
    assign res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign empty          = !r_out_valid;
    assign o_first_x      = r_out.first[0];
    assign o_first_y      = r_out.first[1];
    assign o_first_z      = r_out.first[2];
    assign o_rate_x_out   = r_out.rate[0];
    assign o_rate_y_out   = r_out.rate[1];
    assign o_rate_z_out   = r_out.rate[2];
    assign o_samples_left = r_out.samples_left;
    assign o_offset_known = r_out.offset_known;

    // The front never writes into a full queue.
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue written while full");

    // A result offered by the back end stays offered until taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("back end dropped a waiting result");

    // The remaining calibration count never exceeds the clamp.
    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_samples_left <= COUNT_W'(MAX_CAL_SAMPLES)))
        else $error("samples left beyond the calibration limit");

    // While calibration still collects samples the rates read zero.
    a_cal_rates_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_samples_left != '0)) |->
        (o_rate_x_out == '0) && (o_rate_y_out == '0) && (o_rate_z_out == '0))
        else $error("nonzero rate during calibration");

endmodule
